>>> hw/rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants, register codes and controller/datapath interface types
// for the Manchester frame decoder.
// ----------------------------------------------------------------------------
package mfd_pkg;

   localparam int MAX_HALF_BITS = 156;
   localparam int MAX_SYMBOLS   = 128;
   localparam int START_SPAN    = 68;
   localparam int FRAME_BITS    = 32;

   localparam int DUR_W    = 15;
   localparam int FRAME_W  = 32;
   localparam int STATUS_W = 2;

   localparam int HB_W   = $clog2(MAX_HALF_BITS + 1);
   localparam int ADDR_W = $clog2(MAX_HALF_BITS);
   localparam int POS_W  = $clog2(MAX_HALF_BITS + 2);
   localparam int CMP_W  = $clog2(MAX_HALF_BITS + START_SPAN + 2);
   localparam int SYM_W  = $clog2(MAX_SYMBOLS + 1);
   localparam int BITS_W = $clog2(FRAME_BITS + 1);

   // configuration port
   localparam int APB_AW    = 3;
   localparam int APB_DW    = 32;
   localparam int REG_IDX_W = APB_AW - 2;

   localparam logic [REG_IDX_W-1:0] REG_SPLIT_THRESHOLD = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_IDLE_LIMIT      = 1'b1;

   localparam logic [DUR_W-1:0] SPLIT_THRESHOLD_RST = 15'd750;
   localparam logic [DUR_W-1:0] IDLE_LIMIT_RST      = 15'd1500;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSTART = 2'd2;
   localparam logic [STATUS_W-1:0] ST_PARITY  = 2'd3;

   typedef struct packed {
      logic [DUR_W-1:0] split_threshold;
      logic [DUR_W-1:0] idle_limit;
   } cfg_type;

   typedef struct packed {
      logic                load;       // capture request, count symbol
      logic                wr_half;    // store one pending half-bit
      logic                clr_pos;    // reset scan position and frame
      logic                rd_pair;    // read store at pos, pos+1
      logic                step_one;   // pos += 1
      logic                skip_pair;  // pos += 2
      logic                take_pair;  // pos += 2, shift in bit if valid
      logic                emit;       // present result, clear capture
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic halves_pending;
      logic last;
      logic sym_short;
      logic scan_ok;
      logic pair_start;
      logic bits_more;
      logic bits_full;
      logic parity_odd;
   } stat_type;

endpackage

>>> hw/rtl/mfd_csr.sv
// ----------------------------------------------------------------------------
// mfd_csr
// APB register file: split threshold and idle limit.
// ----------------------------------------------------------------------------
module mfd_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mfd_pkg::APB_AW-1:0] paddr,
   input  logic [mfd_pkg::APB_DW-1:0] pwdata,
   output logic [mfd_pkg::APB_DW-1:0] prdata,
   output logic                       pready,
   output mfd_pkg::cfg_type           cfg
);
   import mfd_pkg::*;

   logic [DUR_W-1:0]     split_ff, split_in;
   logic [DUR_W-1:0]     idle_ff, idle_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[APB_AW-1:2];
   assign wr_en   = psel & penable & pwrite & pready;

   always_comb begin
      split_in = split_ff;
      idle_in  = idle_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_SPLIT_THRESHOLD: split_in = pwdata[DUR_W-1:0];
            REG_IDLE_LIMIT:      idle_in  = pwdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SPLIT_THRESHOLD: prdata = APB_DW'(split_ff);
         REG_IDLE_LIMIT:      prdata = APB_DW'(idle_ff);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff <= SPLIT_THRESHOLD_RST;
         idle_ff  <= IDLE_LIMIT_RST;
      end else begin
         split_ff <= split_in;
         idle_ff  <= idle_in;
      end
   end

   assign cfg.split_threshold = split_ff;
   assign cfg.idle_limit      = idle_ff;

endmodule

>>> hw/rtl/mfd_datapath.sv
// ----------------------------------------------------------------------------
// mfd_datapath
// Half-bit store, capture counters, start search position and frame shifter.
// ----------------------------------------------------------------------------
module mfd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_level_first,
   input  logic [mfd_pkg::DUR_W-1:0]    req_duration_first,
   input  logic                         req_level_second,
   input  logic [mfd_pkg::DUR_W-1:0]    req_duration_second,
   input  logic                         req_last_symbol,
   input  mfd_pkg::cfg_type             cfg,
   input  mfd_pkg::cmd_type             cmd,
   output mfd_pkg::stat_type            stat,
   output logic                         rsp_valid,
   output logic [mfd_pkg::FRAME_W-1:0]  rsp_frame,
   output logic [mfd_pkg::STATUS_W-1:0] rsp_status
);
   import mfd_pkg::*;

   // 0 = skipped, 1 = short, 2 = long
   function automatic logic [1:0] half_count(input logic [DUR_W-1:0] dur,
                                             input cfg_type c);
      logic [1:0] n;
      if (dur == '0 || dur > c.idle_limit)
         n = 2'd0;
      else if (dur < c.split_threshold)
         n = 2'd1;
      else
         n = 2'd2;
      return n;
   endfunction

   logic                lvl1_ff, lvl1_in;
   logic                lvl2_ff, lvl2_in;
   logic [1:0]          rem1_ff, rem1_in;
   logic [1:0]          rem2_ff, rem2_in;
   logic                last_ff, last_in;
   logic [HB_W-1:0]     hb_cnt_ff, hb_cnt_in;
   logic [SYM_W-1:0]    sym_cnt_ff, sym_cnt_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [BITS_W-1:0]   bits_ff, bits_in;
   logic [FRAME_W-1:0]  value_ff, value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]  rsp_frame_ff, rsp_frame_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rd_a_ff, rd_b_ff;
   logic                wr_en;
   logic                wr_lvl;
   logic [POS_W-1:0]    pos_nxt;

   logic mem [MAX_HALF_BITS];

   assign pos_nxt = pos_ff + POS_W'(1);

   always_comb begin
      lvl1_in       = lvl1_ff;
      lvl2_in       = lvl2_ff;
      rem1_in       = rem1_ff;
      rem2_in       = rem2_ff;
      last_in       = last_ff;
      hb_cnt_in     = hb_cnt_ff;
      sym_cnt_in    = sym_cnt_ff;
      pos_in        = pos_ff;
      bits_in       = bits_ff;
      value_in      = value_ff;
      rsp_valid_in  = cmd.emit;
      rsp_frame_in  = rsp_frame_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_lvl        = lvl1_ff;

      if (cmd.load) begin
         lvl1_in = req_level_first;
         lvl2_in = req_level_second;
         last_in = req_last_symbol;
         if (sym_cnt_ff < SYM_W'(MAX_SYMBOLS)) begin
            sym_cnt_in = sym_cnt_ff + SYM_W'(1);
            rem1_in    = half_count(req_duration_first, cfg);
            rem2_in    = half_count(req_duration_second, cfg);
         end else begin
            // symbol past the cap: only its last mark counts
            rem1_in = 2'd0;
            rem2_in = 2'd0;
         end
      end

      if (cmd.wr_half) begin
         if (rem1_ff != 2'd0) begin
            wr_lvl  = lvl1_ff;
            rem1_in = rem1_ff - 2'd1;
         end else begin
            wr_lvl  = lvl2_ff;
            rem2_in = rem2_ff - 2'd1;
         end
         if (hb_cnt_ff < HB_W'(MAX_HALF_BITS)) begin
            wr_en     = 1'b1;
            hb_cnt_in = hb_cnt_ff + HB_W'(1);
         end
      end

      if (cmd.clr_pos) begin
         pos_in   = '0;
         bits_in  = '0;
         value_in = '0;
      end
      if (cmd.step_one)
         pos_in = pos_nxt;
      if (cmd.skip_pair)
         pos_in = pos_ff + POS_W'(2);
      if (cmd.take_pair) begin
         pos_in = pos_ff + POS_W'(2);
         // low-high is 1, high-low is 0, equal halves are dropped
         if (rd_a_ff != rd_b_ff) begin
            value_in = {value_ff[FRAME_W-2:0], rd_b_ff};
            bits_in  = bits_ff + BITS_W'(1);
         end
      end

      if (cmd.emit) begin
         hb_cnt_in     = '0;
         sym_cnt_in    = '0;
         rsp_status_in = cmd.status;
         rsp_frame_in  = (cmd.status == ST_OK) ? value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem1_ff      <= '0;
         rem2_ff      <= '0;
         hb_cnt_ff    <= '0;
         sym_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem1_ff      <= rem1_in;
         rem2_ff      <= rem2_in;
         hb_cnt_ff    <= hb_cnt_in;
         sym_cnt_ff   <= sym_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl1_ff       <= lvl1_in;
      lvl2_ff       <= lvl2_in;
      last_ff       <= last_in;
      pos_ff        <= pos_in;
      bits_ff       <= bits_in;
      value_ff      <= value_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[hb_cnt_ff[ADDR_W-1:0]] <= wr_lvl;
      if (cmd.rd_pair) begin
         rd_a_ff <= mem[pos_ff[ADDR_W-1:0]];
         rd_b_ff <= mem[pos_nxt[ADDR_W-1:0]];
      end
   end

   assign stat.halves_pending = (rem1_ff != 2'd0) || (rem2_ff != 2'd0);
   assign stat.last           = last_ff;
   assign stat.sym_short      = sym_cnt_ff < SYM_W'(2);
   assign stat.scan_ok        = (CMP_W'(pos_ff) + CMP_W'(START_SPAN)) < CMP_W'(hb_cnt_ff);
   assign stat.pair_start     = !rd_a_ff && rd_b_ff;
   assign stat.bits_more      = ((CMP_W'(pos_ff) + CMP_W'(1)) < CMP_W'(hb_cnt_ff))
                                && (bits_ff < BITS_W'(FRAME_BITS));
   assign stat.bits_full      = bits_ff == BITS_W'(FRAME_BITS);
   assign stat.parity_odd     = ^value_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_frame  = rsp_frame_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTH
   a_hb_cap: assert property (@(posedge clock) disable iff (reset)
      hb_cnt_ff <= HB_W'(MAX_HALF_BITS))
      else $error("half-bit count past store size");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back result strobes");

   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> (rsp_frame_ff == '0))
      else $error("nonzero frame with error status");

   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (hb_cnt_ff == '0) && (sym_cnt_ff == '0))
      else $error("capture not cleared after result");
`endif

endmodule

>>> hw/rtl/mfd_ctrl.sv
// ----------------------------------------------------------------------------
// mfd_ctrl
// Sequencer: per-symbol half-bit writes, start search, pair decode, result.
// ----------------------------------------------------------------------------
module mfd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mfd_pkg::stat_type stat,
   output mfd_pkg::cmd_type  cmd
);
   import mfd_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_WRITE    = 3'd1;
   localparam logic [2:0] S_DECODE   = 3'd2;
   localparam logic [2:0] S_SCAN_RD  = 3'd3;
   localparam logic [2:0] S_SCAN_CHK = 3'd4;
   localparam logic [2:0] S_BITS_RD  = 3'd5;
   localparam logic [2:0] S_BITS_CHK = 3'd6;
   localparam logic [2:0] S_FINISH   = 3'd7;

   logic [2:0] state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            if (stat.halves_pending)
               cmd.wr_half = 1'b1;
            else if (stat.last)
               state_in = S_DECODE;
            else
               state_in = S_IDLE;
         end
         S_DECODE: begin
            if (stat.sym_short) begin
               cmd.emit   = 1'b1;
               cmd.status = ST_SHORT;
               state_in   = S_IDLE;
            end else begin
               cmd.clr_pos = 1'b1;
               state_in    = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_ok) begin
               cmd.rd_pair = 1'b1;
               state_in    = S_SCAN_CHK;
            end else begin
               cmd.emit   = 1'b1;
               cmd.status = ST_NOSTART;
               state_in   = S_IDLE;
            end
         end
         S_SCAN_CHK: begin
            if (stat.pair_start) begin
               cmd.skip_pair = 1'b1;
               state_in      = S_BITS_RD;
            end else begin
               cmd.step_one = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_BITS_RD: begin
            if (stat.bits_more) begin
               cmd.rd_pair = 1'b1;
               state_in    = S_BITS_CHK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_BITS_CHK: begin
            cmd.take_pair = 1'b1;
            state_in      = S_BITS_RD;
         end
         S_FINISH: begin
            cmd.emit = 1'b1;
            if (!stat.bits_full)
               cmd.status = ST_NOSTART;
            else if (stat.parity_odd)
               cmd.status = ST_PARITY;
            else
               cmd.status = ST_OK;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/manchester_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// manchester_frame_decoder_top
// Manchester frame decoder: captured pulse symbols in, 32-bit frame and
// status out once per capture.
// ----------------------------------------------------------------------------
// A symbol is taken when start is high and busy is low. Each symbol then
// keeps the block busy while it writes each half-bit it yields, dropped
// ones included, one at a time, since the half-bit store has a single write
// port. A symbol marked last also runs the decode on the store's two read
// ports, reading and then checking each examined position or pair in turn.
// The result sits on rsp_frame/rsp_status for exactly one cycle with
// rsp_valid high and cannot be held off; the next request may be taken in
// that same cycle. Register writes are meant for idle periods only.
module manchester_frame_decoder_top (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_level_first,
   input  logic [mfd_pkg::DUR_W-1:0]    req_duration_first,
   input  logic                         req_level_second,
   input  logic [mfd_pkg::DUR_W-1:0]    req_duration_second,
   input  logic                         req_last_symbol,
   // result channel
   output logic                         rsp_valid,
   output logic [mfd_pkg::FRAME_W-1:0]  rsp_frame,
   output logic [mfd_pkg::STATUS_W-1:0] rsp_status,
   // register port
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mfd_pkg::APB_AW-1:0]   paddr,
   input  logic [mfd_pkg::APB_DW-1:0]   pwdata,
   output logic [mfd_pkg::APB_DW-1:0]   prdata,
   output logic                         pready
);
   import mfd_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   mfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mfd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   mfd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_level_first     (req_level_first),
      .req_duration_first  (req_duration_first),
      .req_level_second    (req_level_second),
      .req_duration_second (req_duration_second),
      .req_last_symbol     (req_last_symbol),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_valid           (rsp_valid),
      .rsp_frame           (rsp_frame),
      .rsp_status          (rsp_status)
   );

endmodule

>>> test/mfd_frame_checker.sv
// ----------------------------------------------------------------------------
// mfd_frame_checker
// Watches the request, result and register ports of the Manchester frame
// decoder. It keeps its own copy of the half-bit capture and the timing
// registers, works out the frame and status each capture should give, and
// compares every result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module mfd_frame_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_level_first,
   input  logic [mfd_pkg::DUR_W-1:0]    req_duration_first,
   input  logic                         req_level_second,
   input  logic [mfd_pkg::DUR_W-1:0]    req_duration_second,
   input  logic                         req_last_symbol,
   input  logic                         rsp_valid,
   input  logic [mfd_pkg::FRAME_W-1:0]  rsp_frame,
   input  logic [mfd_pkg::STATUS_W-1:0] rsp_status,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mfd_pkg::APB_AW-1:0]   paddr,
   input  logic [mfd_pkg::APB_DW-1:0]   pwdata,
   input  logic                         pready,
   output int                           fail_count,
   output int                           pending
);
   import mfd_pkg::*;

   typedef struct packed {
      logic [FRAME_W-1:0]  frame;
      logic [STATUS_W-1:0] status;
   } frame_result_type;

   frame_result_type expected_frames[$];
   bit               hb_store[MAX_HALF_BITS];
   int               half_fill;
   int               symbols_seen;
   logic [DUR_W-1:0] split_cfg;
   logic [DUR_W-1:0] idle_cfg;
   int               errors = 0;
   int               outstanding = 0;

   assign fail_count = errors;
   assign pending    = outstanding;

   task automatic report_miss(input string msg);
      $display("[%0t] checker: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void store_half(input logic lvl, input logic [DUR_W-1:0] dur);
      int copies;
      if (dur == '0 || dur > idle_cfg)
         return;
      copies = (dur < split_cfg) ? 1 : 2;
      repeat (copies) begin
         if (half_fill < MAX_HALF_BITS) begin
            hb_store[half_fill] = lvl;
            half_fill++;
         end
      end
   endfunction

   // symbols past the cap are dropped, but a last mark on one still decodes
   function automatic void take_symbol(input logic lf, input logic [DUR_W-1:0] df,
                                       input logic ls, input logic [DUR_W-1:0] ds);
      if (symbols_seen < MAX_SYMBOLS) begin
         symbols_seen++;
         store_half(lf, df);
         store_half(ls, ds);
      end
   endfunction

   function automatic frame_result_type decode_capture();
      frame_result_type   res;
      int                 sync_at;
      bit                 found;
      int                 nbits;
      logic [FRAME_W-1:0] word;
      int                 p;
      res.frame  = '0;
      res.status = ST_OK;
      sync_at    = 0;
      found      = 1'b0;
      nbits      = 0;
      word       = '0;
      if (symbols_seen < 2) begin
         res.status = ST_SHORT;
         return res;
      end
      // start bit must leave at least START_SPAN half-bits behind it
      for (p = 0; p + START_SPAN < half_fill; p++) begin
         if (hb_store[p] == 1'b0 && hb_store[p+1] == 1'b1) begin
            sync_at = p;
            found   = 1'b1;
            break;
         end
      end
      if (!found) begin
         res.status = ST_NOSTART;
         return res;
      end
      // equal pairs carry no bit and are stepped over
      for (p = sync_at + 2; p + 1 < half_fill && nbits < FRAME_BITS; p += 2) begin
         if (hb_store[p] == 1'b0 && hb_store[p+1] == 1'b1) begin
            word = {word[FRAME_W-2:0], 1'b1};
            nbits++;
         end else if (hb_store[p] == 1'b1 && hb_store[p+1] == 1'b0) begin
            word = {word[FRAME_W-2:0], 1'b0};
            nbits++;
         end
      end
      if (nbits != FRAME_BITS)
         res.status = ST_NOSTART;
      else if (^word)
         res.status = ST_PARITY;
      else
         res.frame = word;
      return res;
   endfunction

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         expected_frames.delete();
         half_fill    = 0;
         symbols_seen = 0;
         split_cfg    = SPLIT_THRESHOLD_RST;
         idle_cfg     = IDLE_LIMIT_RST;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[APB_AW-1:2])
               REG_SPLIT_THRESHOLD: split_cfg = pwdata[DUR_W-1:0];
               REG_IDLE_LIMIT:      idle_cfg  = pwdata[DUR_W-1:0];
               default: ;
            endcase
         end
         // a result may leave in the cycle that takes the next request
         if (rsp_valid === 1'b1) begin
            if (expected_frames.size() == 0) begin
               report_miss($sformatf("result with no request outstanding: frame %h status %0d",
                                     rsp_frame, rsp_status));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_frame !== want.frame)
                  report_miss($sformatf("rsp_frame got %h want %h", rsp_frame, want.frame));
               if (rsp_status !== want.status)
                  report_miss($sformatf("rsp_status got %0d want %0d",
                                        rsp_status, want.status));
            end
         end else if (rsp_valid !== 1'b0) begin
            report_miss("rsp_valid unknown");
         end
         if (start && !busy) begin
            take_symbol(req_level_first, req_duration_first,
                        req_level_second, req_duration_second);
            if (req_last_symbol) begin
               expected_frames.push_back(decode_capture());
               half_fill    = 0;
               symbols_seen = 0;
            end
         end
      end
      outstanding <= expected_frames.size();
   end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Manchester frame decoder: a few hand-picked symbols and
// frames, then random captures (clean and damaged frames, noise, single
// symbols, floods past the store and symbol caps) under several timing
// register settings, with random request gaps. Checking is done by
// mfd_frame_checker; this module drives and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import mfd_pkg::*;

   typedef struct packed {
      logic             lvl;
      logic [DUR_W-1:0] dur;
   } pulse_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_level_first = 1'b0;
   logic [DUR_W-1:0]    req_duration_first = '0;
   logic                req_level_second = 1'b0;
   logic [DUR_W-1:0]    req_duration_second = '0;
   logic                req_last_symbol = 1'b0;
   logic                rsp_valid;
   logic [FRAME_W-1:0]  rsp_frame;
   logic [STATUS_W-1:0] rsp_status;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [APB_AW-1:0]   paddr = '0;
   logic [APB_DW-1:0]   pwdata = '0;
   logic [APB_DW-1:0]   prdata;
   logic                pready;
   int                  fail_count;
   int                  pending;

   pulse_type pulse_q[$];
   int        pulse_idx;
   int        items_sent = 0;
   bit        gaps_on = 1'b0;
   int        stim_split = 750;
   int        stim_idle = 1500;

   manchester_frame_decoder_top dut (
      .clock, .reset, .start, .busy,
      .req_level_first, .req_duration_first,
      .req_level_second, .req_duration_second, .req_last_symbol,
      .rsp_valid, .rsp_frame, .rsp_status,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   mfd_frame_checker frame_chk (
      .clock, .reset, .start, .busy,
      .req_level_first, .req_duration_first,
      .req_level_second, .req_duration_second, .req_last_symbol,
      .rsp_valid, .rsp_frame, .rsp_status,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .fail_count, .pending
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("manchester_frame_decoder_top: mismatch");
      $finish;
   end

   task automatic send_symbol(input logic lf, input logic [DUR_W-1:0] df,
                              input logic ls, input logic [DUR_W-1:0] ds,
                              input logic fin);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start               <= 1'b1;
      req_level_first     <= lf;
      req_duration_first  <= df;
      req_level_second    <= ls;
      req_duration_second <= ds;
      req_last_symbol     <= fin;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // outstanding count is registered, so always wait for a clock edge before testing it
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input int value);
      logic [APB_DW-1:0] word;
      word              = $urandom;
      word[DUR_W-1:0]   = value[DUR_W-1:0];
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timing(input int split, input int idle);
      wait_drained();
      // a non-last request may still be storing half-bits
      repeat (10) @(posedge clock);
      csr_write(REG_SPLIT_THRESHOLD, split);
      csr_write(REG_IDLE_LIMIT, idle);
      stim_split = split;
      stim_idle  = idle;
   endtask

   function automatic logic [DUR_W-1:0] pick_in(input int lo, input int hi);
      case ($urandom_range(0, 5))
         0:       return DUR_W'(lo);
         1:       return DUR_W'(hi);
         default: return DUR_W'($urandom_range(hi, lo));
      endcase
   endfunction

   function automatic bit short_ok();
      return stim_split >= 2 && stim_idle >= 1;
   endfunction

   function automatic bit long_ok();
      return ((stim_split == 0) ? 1 : stim_split) <= stim_idle;
   endfunction

   function automatic logic [DUR_W-1:0] short_dur();
      return pick_in(1, (stim_split - 1 < stim_idle) ? stim_split - 1 : stim_idle);
   endfunction

   function automatic logic [DUR_W-1:0] long_dur();
      return pick_in((stim_split == 0) ? 1 : stim_split, stim_idle);
   endfunction

   function automatic logic [DUR_W-1:0] noise_dur();
      int d;
      case ($urandom_range(0, 7))
         0:       d = 0;
         1:       d = int'($urandom_range(0, 32767));
         2:       d = stim_split + int'($urandom_range(0, 4)) - 2;
         3:       d = stim_idle + int'($urandom_range(0, 4)) - 2;
         4:       d = 32767;
         default: d = int'($urandom_range(1, 2000));
      endcase
      if (d < 0)
         d = 0;
      if (d > 32767)
         d = 32767;
      return DUR_W'(d);
   endfunction

   // absent halves are slipped in now and then
   function automatic pulse_type take_pulse();
      pulse_type p;
      if (pulse_idx < pulse_q.size() && $urandom_range(0, 19) != 0) begin
         p = pulse_q[pulse_idx];
         pulse_idx++;
      end else begin
         p.lvl = 1'($urandom_range(0, 1));
         p.dur = '0;
      end
      return p;
   endfunction

   task automatic send_capture();
      pulse_type a;
      pulse_type b;
      logic      fin;
      pulse_idx = 0;
      do begin
         a   = take_pulse();
         b   = take_pulse();
         fin = (pulse_idx >= pulse_q.size());
         send_symbol(a.lvl, a.dur, b.lvl, b.dur, fin);
      end while (!fin);
   endtask

   task automatic build_noise(input int count);
      pulse_type p;
      pulse_q.delete();
      repeat (count) begin
         p.lvl = 1'($urandom_range(0, 1));
         p.dur = noise_dur();
         pulse_q.push_back(p);
      end
   endtask

   // preamble, start pair, 32 data pairs (msb first), trailer; then runs of
   // equal half-bits are turned into short or long pulses
   task automatic build_frame(input bit prefer_long, input bit use_fixed,
                              input logic [FRAME_W-1:0] fixed_word, input int trailer_len);
      bit                 seq[$];
      logic [FRAME_W-1:0] word;
      int                 n;
      int                 pos;
      int                 i;
      bit                 ones_pre;
      bit                 v;
      pulse_type          p;
      pulse_q.delete();
      word = use_fixed ? fixed_word : FRAME_W'($urandom);
      if (!use_fixed && $urandom_range(0, 2) != 0 && ^word)
         word[0] = ~word[0];
      n        = use_fixed ? 0 : int'($urandom_range(0, 8));
      ones_pre = 1'($urandom_range(0, 1));
      repeat (n) seq.push_back(ones_pre ? 1'b1 : 1'($urandom_range(0, 1)));
      seq.push_back(1'b0);
      seq.push_back(1'b1);
      for (i = FRAME_W - 1; i >= 0; i--) begin
         seq.push_back(~word[i]);
         seq.push_back(word[i]);
      end
      repeat (trailer_len) seq.push_back(1'($urandom_range(0, 1)));
      if (!use_fixed) begin
         case ($urandom_range(0, 9))
            0: begin
               // equal pair at a pair boundary after the start pair: skipped by the decoder
               pos = n + 2 * int'($urandom_range(1, 33));
               v   = 1'($urandom_range(0, 1));
               seq.insert(pos, v);
               seq.insert(pos, v);
            end
            1: begin
               pos      = int'($urandom_range(0, seq.size() - 1));
               seq[pos] = ~seq[pos];
            end
            2: begin
               pos = int'($urandom_range(1, seq.size()));
               while (seq.size() > pos) void'(seq.pop_back());
            end
            default: ;
         endcase
      end
      i = 0;
      while (i < seq.size()) begin
         p.lvl = seq[i];
         if (i + 1 < seq.size() && seq[i+1] == seq[i] && long_ok() &&
             (prefer_long || !short_ok() || $urandom_range(0, 3) != 0)) begin
            p.dur = long_dur();
            i += 2;
         end else if (short_ok()) begin
            p.dur = short_dur();
            i++;
         end else begin
            p.dur = long_ok() ? long_dur() : DUR_W'($urandom_range(1, 32767));
            i++;
         end
         pulse_q.push_back(p);
      end
      if (!use_fixed && $urandom_range(0, 5) == 0) begin
         p.lvl = 1'($urandom_range(0, 1));
         if (stim_idle < 32767 && $urandom_range(0, 1) == 1)
            p.dur = DUR_W'($urandom_range(32767, stim_idle + 1));
         else
            p.dur = '0;
         pulse_q.insert($urandom_range(0, pulse_q.size()), p);
      end
   endtask

   task automatic random_capture(input bit gapless);
      int r;
      gaps_on = !gapless && $urandom_range(0, 2) != 0;
      r = int'($urandom_range(0, 99));
      if (r < 5)
         wait_drained();
      if (r < 68)
         build_frame(1'b0, 1'b0, '0, int'($urandom_range(1, 6)));
      else if (r < 84)
         build_noise(int'($urandom_range(4, 24)));
      else if (r < 96)
         build_noise(int'($urandom_range(1, 3)));
      else if (r < 98)
         build_frame(1'b0, 1'b0, '0, 300);
      else
         build_noise(int'($urandom_range(260, 280)));
      send_capture();
   endtask

   task automatic run_phase(input int split, input int idle, input int budget,
                            input bit gapless);
      int stop_at;
      set_timing(split, idle);
      stop_at = items_sent + budget;
      while (items_sent < stop_at) random_capture(gapless);
   endtask

   initial begin
      int split;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: single-symbol captures, field extremes, threshold edges
      gaps_on = 1'b0;
      send_symbol(1'b0, '0, 1'b0, '0, 1'b1);
      send_symbol(1'b1, 15'h7fff, 1'b1, 15'h7fff, 1'b1);
      send_symbol(1'b1, 15'h7fff, 1'b0, 15'd1500, 1'b0);
      send_symbol(1'b0, 15'd749, 1'b1, 15'd750, 1'b1);
      send_symbol(1'b1, 15'd1501, 1'b1, 15'd1, 1'b0);
      send_symbol(1'b0, '0, 1'b1, '0, 1'b1);
      // alternating bits give long pulses: a clean frame in few requests
      build_frame(1'b1, 1'b1, 32'h5555_5555, 2);
      send_capture();

      // store and symbol count overflow
      gaps_on = 1'b1;
      build_frame(1'b0, 1'b0, '0, 300);
      send_capture();
      build_noise(270);
      send_capture();

      run_phase(750, 1500, 160, 1'b0);
      run_phase(500, 1000, 150, 1'b0);
      split = int'($urandom_range(50, 3000));
      run_phase(split, split + int'($urandom_range(0, 3 * split)), 150, 1'b0);
      run_phase(1, 32767, 130, 1'b0);
      run_phase(32767, 32767, 130, 1'b0);
      run_phase(0, 0, 40, 1'b0);
      run_phase(0, 32767, 120, 1'b0);
      run_phase(2000, 1000, 130, 1'b0);
      run_phase(750, 1500, 210, 1'b1);

      wait_drained();
      repeat (400) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("manchester_frame_decoder_top: match");
      else
         $display("manchester_frame_decoder_top: mismatch");
      $finish;
   end

endmodule
